// File: hdl/fahl_pkg.sv
// ----------------------------------------------------------------------------
// fahl_pkg
// shared constants, register indexes and types of the half-life unit
// ----------------------------------------------------------------------------
package fahl_pkg;

   // fixed-point formats and divider steps
   localparam int FRAC_BITS = 16;
   localparam int LOG_BITS  = 26;
   localparam int DIV_STEPS = 32;

   // register indexes
   localparam logic [2:0] CSR_GAIN     = 3'd0;
   localparam logic [2:0] CSR_OFFSET   = 3'd1;
   localparam logic [2:0] CSR_FPS      = 3'd2;
   localparam logic [2:0] CSR_SHORTEST = 3'd3;
   localparam logic [2:0] CSR_LONGEST  = 3'd4;

   // register reset values and the frame-rate floor
   localparam logic [23:0] GAIN_RESET     = 24'd65536;
   localparam logic [23:0] OFFSET_RESET   = 24'd0;
   localparam logic [31:0] FPS_RESET      = 32'd1966080;
   localparam logic [31:0] SHORTEST_RESET = 32'd6554;
   localparam logic [31:0] LONGEST_RESET  = 32'd3932160;
   localparam logic [31:0] MIN_FPS        = 32'd66;

   // control travelling with each word
   typedef struct packed {
      logic valid;
      logic sat;
   } fahl_ctl_type;

endpackage

// File: hdl/fahl_req_if.sv
// ----------------------------------------------------------------------------
// fahl_req_if
// request channel carrying one control sample per word
// ----------------------------------------------------------------------------
interface fahl_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/fahl_rsp_if.sv
// ----------------------------------------------------------------------------
// fahl_rsp_if
// response channel carrying one half-life per word
// ----------------------------------------------------------------------------
interface fahl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] half_life;

   modport source (output valid, output half_life, input ready);
   modport sink   (input valid, input half_life, output ready);
endinterface

// File: hdl/fade_alpha_to_half_life_unit.sv
// ----------------------------------------------------------------------------
// fade_alpha_to_half_life_unit
// maps a control sample to a clamped fade half-life in seconds
// ----------------------------------------------------------------------------
// usage
//   req carries one signed Q8.16 sample per word, rsp one unsigned Q16.16
//   half-life per word; every request word gives exactly one response word
//   in order. the csr port writes gain, offset, frame rate and the two
//   clamps by index; write only while the unit is idle (it is not checked).
// stages and throughput
//   two front stages, 26 log2 squaring stages (one 27 x 27 square each),
//   one frame-rate multiply, 32 divider stages and the clamp register. one
//   word per cycle while rsp is not held off.
// reset
//   synchronous, active high: registers take their defaults (gain 1.0,
//   30 fps, clamps 0.1 s and 60 s) and the pipeline empties.
// stall
//   while rsp is held off with a word waiting, the whole pipeline freezes
//   and req.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fade_alpha_to_half_life_unit (
   input  logic        clock,
   input  logic        reset,
   fahl_req_if.sink    req,
   fahl_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import fahl_pkg::*;

   logic [23:0] gain_ff;
   logic [23:0] offset_ff;
   logic [31:0] fps_ff;
   logic [31:0] shortest_ff;
   logic [31:0] longest_ff;

   logic [31:0] lo_eff;
   logic [31:0] hi_eff;
   logic [31:0] fps_eff;
   logic        en;

   fahl_ctl_type ctl_front;
   fahl_ctl_type ctl_log;
   logic [3:0]   msb_front;
   logic [3:0]   msb_log;
   logic [26:0]  x_front;
   logic [25:0]  frac_log;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_RESET;
         offset_ff   <= OFFSET_RESET;
         fps_ff      <= FPS_RESET;
         shortest_ff <= SHORTEST_RESET;
         longest_ff  <= LONGEST_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN:     gain_ff     <= csr_wdata[23:0];
            CSR_OFFSET:   offset_ff   <= csr_wdata[23:0];
            CSR_FPS:      fps_ff      <= csr_wdata;
            CSR_SHORTEST: shortest_ff <= csr_wdata;
            CSR_LONGEST:  longest_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective clamps and frame rate
   always_comb begin
      lo_eff  = (shortest_ff == 32'd0) ? 32'd1 : shortest_ff;
      hi_eff  = (longest_ff < lo_eff) ? lo_eff : longest_ff;
      fps_eff = (fps_ff < MIN_FPS) ? MIN_FPS : fps_ff;
   end

   // pipeline advances unless the output word is held
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   fahl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req.valid),
      .sample   (req.sample),
      .gain     (signed'(gain_ff)),
      .offset   (signed'(offset_ff)),
      .ctl_out  (ctl_front),
      .msb_out  (msb_front),
      .x_out    (x_front)
   );

   fahl_log u_log (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (ctl_front),
      .msb_in   (msb_front),
      .x_in     (x_front),
      .ctl_out  (ctl_log),
      .msb_out  (msb_log),
      .frac_out (frac_log)
   );

   fahl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (ctl_log),
      .msb_in    (msb_log),
      .frac_in   (frac_log),
      .fps       (fps_eff),
      .lo        (lo_eff),
      .hi        (hi_eff),
      .out_valid (rsp.valid),
      .half_life (rsp.half_life)
   );

`ifndef SYNTH
   // response always lies inside the effective clamps
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.half_life <= hi_eff) && (rsp.half_life >= lo_eff))
      else $error("half-life outside clamps");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("response after reset");

   // a waiting word with no taker freezes the request side
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request taken during stall");
`endif
endmodule

// File: hdl/fahl_front.sv
// ----------------------------------------------------------------------------
// fahl_front
// scales the sample to alpha, clamps it and normalises 1-alpha for the log
// ----------------------------------------------------------------------------
module fahl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [23:0]    sample,
   input  logic signed [23:0]    gain,
   input  logic signed [23:0]    offset,
   output fahl_pkg::fahl_ctl_type ctl_out,
   output logic [3:0]            msb_out,
   output logic [26:0]           x_out
);
   import fahl_pkg::*;

   logic signed [47:0] prod_ff;
   logic               v1_ff;
   fahl_ctl_type       ctl_ff;
   logic [3:0]         msb_ff;
   logic [26:0]        x_ff;

   logic signed [47:0] shifted;
   logic signed [33:0] alpha;
   logic               sat;
   logic [15:0]        r;
   logic [3:0]         msb;

   // stage one: product
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         prod_ff <= sample * gain;
      end
   end

   // alpha, clamp, leading one of 1-alpha
   always_comb begin
      shifted = prod_ff >>> FRAC_BITS;
      alpha   = shifted[33:0] + {{10{offset[23]}}, offset};
      sat     = alpha[33] || (alpha == 34'sd0);
      if (sat || (alpha >= 34'sd65535)) begin
         r = 16'd1;
      end else begin
         r = 16'(17'h10000 - {1'b0, alpha[15:0]});
      end
      msb = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (r[i]) begin
            msb = 4'(i);
         end
      end
   end

   // stage two: normalised mantissa
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= '{valid: v1_ff, sat: sat};
      end
      if (en) begin
         msb_ff <= msb;
         x_ff   <= {11'd0, r} << (5'd26 - {1'b0, msb});
      end
   end

   assign ctl_out = ctl_ff;
   assign msb_out = msb_ff;
   assign x_out   = x_ff;
endmodule

// File: hdl/fahl_log.sv
// ----------------------------------------------------------------------------
// fahl_log
// fraction bits of log2 by repeated squaring, one bit per stage
// ----------------------------------------------------------------------------
module fahl_log (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  fahl_pkg::fahl_ctl_type ctl_in,
   input  logic [3:0]            msb_in,
   input  logic [26:0]           x_in,
   output fahl_pkg::fahl_ctl_type ctl_out,
   output logic [3:0]            msb_out,
   output logic [25:0]           frac_out
);
   import fahl_pkg::*;

   fahl_ctl_type ctl_ff  [1:LOG_BITS];
   logic [3:0]   msb_ff  [1:LOG_BITS];
   logic [26:0]  x_ff    [1:LOG_BITS];
   logic [25:0]  frac_ff [1:LOG_BITS];

   for (genvar s = 0; s < LOG_BITS; s++) begin : g_sq
      fahl_ctl_type ctl_cur;
      logic [3:0]   msb_cur;
      logic [26:0]  x_cur;
      logic [25:0]  frac_cur;
      logic [53:0]  sq;
      logic [27:0]  top;

      // stage input: the ports for the first stage, else the previous stage
      if (s == 0) begin : g_head
         assign ctl_cur  = ctl_in;
         assign msb_cur  = msb_in;
         assign x_cur    = x_in;
         assign frac_cur = '0;
      end else begin : g_body
         assign ctl_cur  = ctl_ff[s];
         assign msb_cur  = msb_ff[s];
         assign x_cur    = x_ff[s];
         assign frac_cur = frac_ff[s];
      end

      // square and renormalise
      always_comb begin
         sq  = x_cur * x_cur;
         top = sq[53:26];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else if (en) begin
            ctl_ff[s+1] <= ctl_cur;
         end
         if (en) begin
            msb_ff[s+1]  <= msb_cur;
            x_ff[s+1]    <= top[27] ? top[27:1] : top[26:0];
            frac_ff[s+1] <= {frac_cur[24:0], top[27]};
         end
      end
   end

   assign ctl_out  = ctl_ff[LOG_BITS];
   assign msb_out  = msb_ff[LOG_BITS];
   assign frac_out = frac_ff[LOG_BITS];
endmodule

// File: hdl/fahl_div.sv
// ----------------------------------------------------------------------------
// fahl_div
// scales the log by the frame rate, divides 2^58 by it and clamps
// ----------------------------------------------------------------------------
module fahl_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  fahl_pkg::fahl_ctl_type ctl_in,
   input  logic [3:0]            msb_in,
   input  logic [25:0]           frac_in,
   input  logic [31:0]           fps,
   input  logic [31:0]           lo,
   input  logic [31:0]           hi,
   output logic                  out_valid,
   output logic [31:0]           half_life
);
   import fahl_pkg::*;

   fahl_ctl_type ctl_ff [0:DIV_STEPS];
   logic [62:0]  d_ff   [0:DIV_STEPS];
   logic [62:0]  rem_ff [0:DIV_STEPS];
   logic [31:0]  q_ff   [0:DIV_STEPS];

   logic [30:0] l_val;
   logic [62:0] d_val;
   logic        v_out_ff;
   logic [31:0] res_ff;

   // log value and divisor
   always_comb begin
      l_val = {5'(5'd16 - {1'b0, msb_in}), 26'd0} - {5'd0, frac_in};
      d_val = l_val * fps;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= '{valid: ctl_in.valid,
                        sat: ctl_in.sat || (d_val <= 63'h400_0000)};
      end
      if (en) begin
         d_ff[0]   <= d_val;
         rem_ff[0] <= 63'h400_0000;
         q_ff[0]   <= '0;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      logic [63:0] t;
      logic        ge;

      always_comb begin
         t  = {rem_ff[s], 1'b0};
         ge = t >= {1'b0, d_ff[s]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else if (en) begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
         if (en) begin
            d_ff[s+1]   <= d_ff[s];
            rem_ff[s+1] <= ge ? 63'(t - {1'b0, d_ff[s]}) : t[62:0];
            q_ff[s+1]   <= {q_ff[s][30:0], ge};
         end
      end
   end

   // clamp into the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         v_out_ff <= 1'b0;
      end else if (en) begin
         v_out_ff <= ctl_ff[DIV_STEPS].valid;
      end
      if (en) begin
         if (ctl_ff[DIV_STEPS].sat || (q_ff[DIV_STEPS] > hi)) begin
            res_ff <= hi;
         end else if (q_ff[DIV_STEPS] < lo) begin
            res_ff <= lo;
         end else begin
            res_ff <= q_ff[DIV_STEPS];
         end
      end
   end

   assign out_valid = v_out_ff;
   assign half_life = res_ff;
endmodule
